// ===== design/wnss_pkg.sv =====
// shared types and constants for the weighted nearest seed search
`timescale 1ns / 1ps
package wnss_pkg;
  localparam int DefMaxSeeds = 64;
  localparam int DefRealms = 4;
  localparam int DefGridSize = 100;
  localparam int Dims = 5;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  // one item as queued between front and back
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] realm;
    logic [15:0] biome_id;
    logic [7:0] priority_req;
    logic [15:0] score_offset;
    logic [15:0] c0;
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
  } item_t;

  function automatic logic [2:0] axis_w4(input int i);
    case (i)
      2: axis_w4 = 3'd3;
      4: axis_w4 = 3'd6;
      default: axis_w4 = 3'd4;
    endcase
  endfunction
endpackage

// ===== design/weighted_nearest_seed_search.sv =====
// top level of the weighted nearest seed search
`timescale 1ns / 1ps
// clear and append: the result is registered in the back end state once the item leaves the queue;
// the back end takes no new item until the result is taken; query: the result follows the table
// scan and the pipeline drain; one seed read per cycle through a four-stage scoring pipeline
// a two-entry queue takes new transactions while the back end is busy
// rst (synchronous) empties the table count and the queue; table contents stay
module weighted_nearest_seed_search #(
  parameter int MAX_SEEDS = wnss_pkg::DefMaxSeeds,
  parameter int REALMS = wnss_pkg::DefRealms,
  parameter int GRID_SIZE = wnss_pkg::DefGridSize
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input logic [1:0] kind,
  input logic [3:0] realm,
  input logic [15:0] biome_id,
  input logic [7:0] priority_req,
  input logic signed [15:0] score_offset,
  input logic signed [15:0] coord_0,
  input logic signed [15:0] coord_1,
  input logic signed [15:0] coord_2,
  input logic signed [15:0] coord_3,
  input logic signed [15:0] coord_4,
  output logic out_valid,
  input logic out_ready,
  output logic [1:0] status,
  output logic [15:0] best_id
);
  import wnss_pkg::*;

  item_t in_item;
  item_t q_item;
  logic q_valid;
  logic q_ready;

  // pack the input transaction
  assign in_item = '{kind: kind, realm: realm, biome_id: biome_id,
    priority_req: priority_req, score_offset: score_offset,
    c0: coord_0, c1: coord_1, c2: coord_2, c3: coord_3, c4: coord_4};

  // front end: accept and buffer
  wnss_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  // back end: table, scan and result
  wnss_back #(
    .MAX_SEEDS(MAX_SEEDS), .REALMS(REALMS), .GRID_SIZE(GRID_SIZE)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .best_id(best_id)
  );
endmodule

// ===== design/wnss_front.sv =====
// input stage and two-entry item queue
`timescale 1ns / 1ps
module wnss_front (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input wnss_pkg::item_t in_item,
  output logic q_valid,
  input logic q_ready,
  output wnss_pkg::item_t q_item
);
  import wnss_pkg::*;

  item_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  logic push;
  logic pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_item = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue overfill");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers out of step");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !push)
    else $error("push into full queue");
`endif
endmodule

// ===== design/wnss_back.sv =====
// seed table, scan sequencer and scoring pipeline
`timescale 1ns / 1ps
module wnss_back #(
  parameter int MAX_SEEDS = wnss_pkg::DefMaxSeeds,
  parameter int REALMS = wnss_pkg::DefRealms,
  parameter int GRID_SIZE = wnss_pkg::DefGridSize
) (
  input logic clk,
  input logic rst,
  input logic q_valid,
  output logic q_ready,
  input wnss_pkg::item_t q_item,
  output logic out_valid,
  input logic out_ready,
  output logic [1:0] status,
  output logic [15:0] best_id
);
  import wnss_pkg::*;

  localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CW = $clog2(MAX_SEEDS + 1);
  localparam int PW = 7;
  localparam int G1 = GRID_SIZE - 1;
  localparam logic [PW-1:0] G1V = PW'(G1);
  localparam logic [13:0] G1SQ = 14'(G1 * G1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [5*PW-1:0] place_mem [MAX_SEEDS];
  logic [43:0] attr_mem [MAX_SEEDS];

  logic [1:0] state;
  logic [CW-1:0] seed_count;
  logic [CW-1:0] scan_idx;
  logic [3:0] cur_realm;
  logic [15:0] unum [Dims];

  // stage 1 read data
  logic rd_v;
  logic [5*PW-1:0] rd_place;
  logic [43:0] rd_attr;
  // stage 2 deltas
  logic s2_v;
  logic signed [26:0] s2_n [Dims];
  logic signed [15:0] s2_off;
  logic [7:0] s2_prio;
  logic [15:0] s2_id;
  // stage 3 squares
  logic s3_v;
  logic signed [54:0] s3_sq [Dims];
  logic signed [45:0] s3_offm;
  logic [7:0] s3_prio;
  logic [15:0] s3_id;
  // stage 4 score
  logic s4_v;
  logic signed [57:0] s4_score;
  logic [7:0] s4_prio;
  logic [15:0] s4_id;

  logic found;
  logic signed [57:0] lead_score;
  logic [7:0] best_prio;
  logic [15:0] best_idr;

  function automatic logic [PW-1:0] clamp_grid(input logic [15:0] raw);
    logic signed [15:0] v;
    v = raw;
    if (v < 0) clamp_grid = '0;
    else if (v > $signed(16'(G1))) clamp_grid = G1V;
    else clamp_grid = raw[PW-1:0];
  endfunction

  logic q_take;
  assign q_ready = (state == S_IDLE);
  assign q_take = q_valid && q_ready;
  assign out_valid = (state == S_OUT);
  assign best_id = best_idr;

  logic pipe_busy;
  assign pipe_busy = rd_v || s2_v || s3_v || s4_v;

  always_ff @(posedge clk) begin
    // table write on append
    if (q_take && q_item.kind == KIND_APPEND && seed_count < CW'(MAX_SEEDS)) begin
      place_mem[seed_count[AW-1:0]] <= {clamp_grid(q_item.c4), clamp_grid(q_item.c3),
        clamp_grid(q_item.c2), clamp_grid(q_item.c1), clamp_grid(q_item.c0)};
      attr_mem[seed_count[AW-1:0]] <= {q_item.score_offset, q_item.priority_req,
        q_item.biome_id, q_item.realm};
    end
    rd_place <= place_mem[scan_idx[AW-1:0]];
    rd_attr <= attr_mem[scan_idx[AW-1:0]];

    if (q_take) begin
      cur_realm <= q_item.realm;
      unum[0] <= q_item.c0 ^ 16'h8000;
      unum[1] <= q_item.c1 ^ 16'h8000;
      unum[2] <= q_item.c2 ^ 16'h8000;
      unum[3] <= q_item.c3 ^ 16'h8000;
      unum[4] <= q_item.c4 ^ 16'h8000;
    end

    // stage 2: weighted delta per axis
    for (int i = 0; i < Dims; i++) begin
      s2_n[i] <= 27'(signed'({1'b0, axis_w4(i)})) *
        (27'(signed'({1'b0, unum[i]})) * 27'(signed'({1'b0, G1V}))
         - 27'(signed'({1'b0, rd_place[i*PW +: PW], 16'd0})));
    end
    s2_off <= rd_attr[43:28];
    s2_prio <= rd_attr[27:20];
    s2_id <= rd_attr[19:4];
    // stage 3: squares and offset term
    for (int i = 0; i < Dims; i++) begin
      s3_sq[i] <= 55'(s2_n[i]) * 55'(s2_n[i]);
    end
    s3_offm <= 46'(s2_off) * 46'(signed'({1'b0, G1SQ}));
    s3_prio <= s2_prio;
    s3_id <= s2_id;
    // stage 4: sum
    s4_score <= 58'(s3_sq[0]) + 58'(s3_sq[1]) + 58'(s3_sq[2]) + 58'(s3_sq[3])
      + 58'(s3_sq[4]) + (58'(s3_offm) <<< 24);
    s4_prio <= s3_prio;
    s4_id <= s3_id;

    if (rst) begin
      state <= S_IDLE;
      seed_count <= '0;
      scan_idx <= '0;
      rd_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      found <= 1'b0;
      status <= ST_OK;
      best_idr <= '0;
    end else begin
      rd_v <= (state == S_SCAN) && (scan_idx < seed_count);
      // realm filter on stage 2 input
      s2_v <= rd_v && (rd_attr[3:0] == cur_realm);
      s3_v <= s2_v;
      s4_v <= s3_v;
      if (s4_v && (!found || s4_score < lead_score ||
          (s4_score == lead_score && s4_prio > best_prio))) begin
        found <= 1'b1;
        lead_score <= s4_score;
        best_prio <= s4_prio;
        best_idr <= s4_id;
      end
      case (state)
        S_IDLE: begin
          if (q_take) begin
            best_idr <= '0;
            found <= 1'b0;
            scan_idx <= '0;
            case (q_item.kind)
              KIND_CLEAR: begin
                seed_count <= '0;
                status <= ST_OK;
                state <= S_OUT;
              end
              KIND_APPEND: begin
                if (seed_count < CW'(MAX_SEEDS)) begin
                  seed_count <= seed_count + 1'b1;
                  status <= ST_OK;
                end else begin
                  status <= ST_FULL;
                end
                state <= S_OUT;
              end
              KIND_QUERY: begin
                if (32'(q_item.realm) < REALMS) begin
                  status <= ST_OK;
                  state <= S_SCAN;
                end else begin
                  status <= ST_NOMATCH;
                  state <= S_OUT;
                end
              end
              default: begin
                status <= ST_OK;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_idx < seed_count) scan_idx <= scan_idx + 1'b1;
          else state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!pipe_busy) begin
            state <= S_OUT;
            if (!found) status <= ST_NOMATCH;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    seed_count <= CW'(MAX_SEEDS))
    else $error("seed count over table size");
  a_pipe_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !pipe_busy)
    else $error("result shown with scan in flight");
  a_nomatch_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> best_id == 16'd0)
    else $error("id on failed result");
`endif
endmodule
